// File: rtl/core/pdib_pkg.sv
`default_nettype none

package pdib_pkg;

    typedef enum logic [1:0] {
        OP_STEP         = 2'd0,
        OP_LOAD_INTEG   = 2'd1,
        OP_BUMPLESS     = 2'd2,
        OP_STORE_POINTS = 2'd3
    } op_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_OFFSET = 3'd4;

    // 8999.0 and 5.0 in q16.16
    localparam logic signed [31:0] INTEG_LIMIT = 32'sd589758464;
    localparam logic signed [31:0] INTEG_BAND  = 32'sd327680;

    typedef struct packed {
        logic signed [31:0] prop_gain;
        logic signed [31:0] integ_gain;
        logic signed [31:0] deriv_gain;
        logic        [30:0] dead_band;
        logic signed [31:0] output_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] prev_error;
        logic signed [31:0] integ_acc;
        logic signed [31:0] held_process;
        logic signed [31:0] held_setpoint;
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/pdib_in_if.sv
`default_nettype none

interface pdib_in_if;
    logic               valid;
    logic               ready;
    pdib_pkg::op_t      op;
    logic signed [31:0] process_value;
    logic signed [31:0] set_value;
    logic signed [31:0] integral_value;

    modport source (
        output valid,
        output op,
        output process_value,
        output set_value,
        output integral_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  process_value,
        input  set_value,
        input  integral_value,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/pdib_out_if.sv
`default_nettype none

interface pdib_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] control_out;

    modport source (
        output valid,
        output control_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  control_out,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/pdib_step.sv
`default_nettype none

module pdib_step (
    input  var pdib_pkg::op_t      op,
    input  var logic signed [31:0] process_value,
    input  var logic signed [31:0] set_value,
    input  var logic signed [31:0] integral_value,
    input  var pdib_pkg::cfg_t     cfg,
    input  var pdib_pkg::state_t   state,
    output var logic signed [31:0] control_out,
    output var pdib_pkg::state_t   state_next
);

    function automatic logic signed [31:0] sat_to_32(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end
        if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    logic signed [32:0] err_wide;
    logic signed [31:0] err;
    logic signed [32:0] err33;
    logic signed [32:0] db33;
    logic               ge_band;
    logic               below_band;
    logic               outside_db;
    logic signed [32:0] diff_wide;
    logic signed [31:0] diff;
    logic signed [63:0] p_prod;
    logic signed [63:0] i_prod;
    logic signed [63:0] d_prod;
    logic signed [47:0] pterm;
    logic signed [47:0] iterm;
    logic signed [47:0] dterm;
    logic signed [48:0] acc;
    logic signed [31:0] integ_new;
    logic signed [51:0] pd_sum;
    logic signed [51:0] full_sum;
    logic signed [32:0] bump_wide;

    assign err_wide   = 33'(set_value) - 33'(process_value);
    assign err        = sat_to_32(52'(err_wide));
    assign err33      = 33'(err);
    assign db33       = $signed({2'b00, cfg.dead_band});
    assign ge_band    = err >= pdib_pkg::INTEG_BAND;
    assign below_band = err < -pdib_pkg::INTEG_BAND;
    assign outside_db = (err33 >= db33) || (err33 < -db33);

    assign diff_wide  = 33'(err) - 33'(state.prev_error);
    assign diff       = sat_to_32(52'(diff_wide));

    // q16.16 products, floor on the shift
    assign p_prod = cfg.prop_gain * err;
    assign i_prod = cfg.integ_gain * err;
    assign d_prod = cfg.deriv_gain * diff;
    assign pterm  = $signed(p_prod[63:16]);
    assign iterm  = $signed(i_prod[63:16]);
    assign dterm  = $signed(d_prod[63:16]);

    assign acc = 49'(state.integ_acc) + 49'(iterm);

    always_comb
    begin
        if (acc > 49'(pdib_pkg::INTEG_LIMIT)) begin
            integ_new = pdib_pkg::INTEG_LIMIT;
        end else begin
            integ_new = sat_to_32(52'(acc));
        end
    end

    assign pd_sum   = 52'(pterm) + 52'(dterm);
    assign full_sum = pd_sum + 52'(integ_new) + 52'(cfg.output_offset);

    assign bump_wide = 33'(state.held_setpoint) - 33'(state.held_process);

    always_comb
    begin
        state_next  = state;
        control_out = '0;
        unique case (op)
            pdib_pkg::OP_LOAD_INTEG: begin
                state_next.integ_acc = integral_value;
            end
            pdib_pkg::OP_BUMPLESS: begin
                state_next.prev_error = sat_to_32(52'(bump_wide));
            end
            pdib_pkg::OP_STORE_POINTS: begin
                state_next.held_process  = process_value;
                state_next.held_setpoint = set_value;
            end
            pdib_pkg::OP_STEP: begin
                state_next.held_process  = process_value;
                state_next.held_setpoint = set_value;
                if (ge_band) begin
                    // large positive error drives INTEG_LIMIT; prev_error and integrator untouched
                    control_out = pdib_pkg::INTEG_LIMIT;
                end else begin
                    state_next.prev_error = err;
                    if (outside_db) begin
                        if (below_band) begin
                            state_next.integ_acc = '0;
                            control_out          = sat_to_32(pd_sum);
                        end else begin
                            state_next.integ_acc = integ_new;
                            control_out          = sat_to_32(full_sum);
                        end
                    end else begin
                        control_out = state.integ_acc;
                    end
                end
            end
            default: begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/pid_deadband_integral_band_unit.sv
// channel  | role   | word
// ---------+--------+-------------------------------------------------------
// sample   | sink   | op, process_value, set_value, integral_value
// drive    | source | control_out
// cfg_*    | write  | cfg_index selects register, cfg_wdata written on cfg_we
//
// one word per cycle sustained while drive is ready: a word is held in the input
// register, then the control step (three 32x32 multiplies and the saturating sums)
// runs in one combinational pass into the result register.
// loop state and the result register update in the same cycle, so the next
// word sees the state left by this one. rst_n clears state, gains and both
// valid flags; a stall on drive holds both registers and backs up sample.
`default_nettype none

module pid_deadband_integral_band_unit (
    input  var logic                                clk,
    input  var logic                                rst_n,
    pdib_in_if.sink                                 sample,
    pdib_out_if.source                              drive,
    input  var logic                                cfg_we,
    input  var logic [pdib_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  var logic [pdib_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    pdib_pkg::cfg_t     cfg_reg;
    pdib_pkg::state_t   state_reg;
    pdib_pkg::state_t   state_next;

    logic               s1_valid_reg;
    pdib_pkg::op_t      s1_op_reg;
    logic signed [31:0] s1_pv_reg;
    logic signed [31:0] s1_sv_reg;
    logic signed [31:0] s1_iv_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_data_reg;
    logic signed [31:0] out_data_next;

    logic               s1_adv;
    logic               s1_fire;
    logic               in_fire;

    // stage advances when the result register is free or being emptied
    assign s1_adv       = !out_valid_reg || drive.ready;
    assign s1_fire      = s1_valid_reg && s1_adv;
    assign sample.ready = !s1_valid_reg || s1_adv;
    assign in_fire      = sample.valid && sample.ready;

    assign drive.valid       = out_valid_reg;
    assign drive.control_out = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pdib_pkg::REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_wdata;
                pdib_pkg::REG_INTEG_GAIN:    cfg_reg.integ_gain    <= cfg_wdata;
                pdib_pkg::REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= cfg_wdata;
                pdib_pkg::REG_DEAD_BAND:     cfg_reg.dead_band     <= cfg_wdata[30:0];
                pdib_pkg::REG_OUTPUT_OFFSET: cfg_reg.output_offset <= cfg_wdata;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (sample.ready) begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s1_op_reg <= sample.op;
            s1_pv_reg <= sample.process_value;
            s1_sv_reg <= sample.set_value;
            s1_iv_reg <= sample.integral_value;
        end
    end

    pdib_step u_step (
        .op             (s1_op_reg),
        .process_value  (s1_pv_reg),
        .set_value      (s1_sv_reg),
        .integral_value (s1_iv_reg),
        .cfg            (cfg_reg),
        .state          (state_reg),
        .control_out    (out_data_next),
        .state_next     (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (s1_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire) begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTH
    a_state_only_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(state_reg))
        else $error("loop state changed with no word in the step");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared with no word in the input stage");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample.ready)
        else $error("input stalled while result register empty");

    a_maint_ops_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_op_reg != pdib_pkg::OP_STEP) |=> out_data_reg == 32'sd0)
        else $error("maintenance word gave a nonzero drive value");
`endif

endmodule

`default_nettype wire
